// File: hdl/object_file_section_parser_top_defines.svh
// ----------------------------------------------------------------------------
// object file section parser assertion macros
// shared assertion shorthands for the parser top level
// ----------------------------------------------------------------------------
`ifndef OBJECT_FILE_SECTION_PARSER_TOP_DEFINES_SVH
`define OBJECT_FILE_SECTION_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osp assertion failed");

// next-cycle implication, checked outside reset
`define OSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osp assertion failed");

`endif

// File: hdl/osp_pkg.sv
// ----------------------------------------------------------------------------
// osp_pkg
// shared types and constants of the object file section parser
// ----------------------------------------------------------------------------
package osp_pkg;

  localparam logic [15:0] HDR_DATA   = 16'hDADA;
  localparam logic [15:0] HDR_CODE   = 16'hCADE;
  localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;

  // parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_ADDRESS = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_WORDS   = 3'd3;
  localparam logic [2:0] PH_LABEL   = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  // section kinds
  localparam logic [1:0] SEC_MEM   = 2'd0;
  localparam logic [1:0] SEC_SYM   = 2'd1;
  localparam logic [1:0] SEC_OTHER = 2'd2;

  // record kinds on the result channel
  localparam logic [1:0] REC_MEM   = 2'd0;
  localparam logic [1:0] REC_LABEL = 2'd1;
  localparam logic [1:0] REC_END   = 2'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one queue entry: what one input byte causes
  typedef struct packed {
    logic        rec_vld;
    logic [1:0]  rec_kind;
    logic [15:0] rec_addr;
    logic [15:0] rec_val;
    logic        end_vld;
    logic        end_status;
  } osp_entry_t;

endpackage

// File: hdl/osp_front.sv
// ----------------------------------------------------------------------------
// osp_front
// byte parser: pairs bytes into words, tracks sections, builds queue entries
// ----------------------------------------------------------------------------
module osp_front import osp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  input  logic       q_full,
  output logic       q_push,
  output osp_entry_t q_entry
);

  logic [2:0]  phase_r, phase_nxt;
  logic        hbp_r, hbp_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic        accept;
  logic [15:0] word;
  osp_entry_t  ent;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign word     = {held_r, in_byte};

  always_comb begin
    phase_nxt = phase_r;
    hbp_nxt   = hbp_r;
    held_nxt  = held_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    ent       = '0;

    unique case (phase_r) inside
      PH_HEADER, PH_ADDRESS, PH_COUNT, PH_WORDS: begin
        if (!hbp_r) begin
          held_nxt = in_byte;
          hbp_nxt  = 1'b1;
        end else begin
          hbp_nxt = 1'b0;
          case (phase_r)
            PH_HEADER: begin
              if (word == HDR_CODE || word == HDR_DATA) kind_nxt = SEC_MEM;
              else if (word == HDR_SYMBOL)              kind_nxt = SEC_SYM;
              else                                      kind_nxt = SEC_OTHER;
              phase_nxt = PH_ADDRESS;
            end
            PH_ADDRESS: begin
              addr_nxt  = word;
              phase_nxt = PH_COUNT;
            end
            PH_COUNT: begin
              rem_nxt = word;
              idx_nxt = '0;
              if (word == 16'd0)         phase_nxt = PH_HEADER;
              else if (kind_r == SEC_MEM) phase_nxt = PH_WORDS;
              else if (kind_r == SEC_SYM) phase_nxt = PH_LABEL;
              else                        phase_nxt = PH_SKIP;
            end
            default: begin
              ent.rec_vld  = 1'b1;
              ent.rec_kind = REC_MEM;
              ent.rec_addr = addr_r + idx_r;
              ent.rec_val  = word;
              idx_nxt      = idx_r + 16'd1;
              rem_nxt      = rem_r - 16'd1;
              if (rem_r == 16'd1) phase_nxt = PH_HEADER;
            end
          endcase
        end
      end
      PH_LABEL: begin
        ent.rec_vld  = 1'b1;
        ent.rec_kind = REC_LABEL;
        ent.rec_addr = addr_r;
        ent.rec_val  = {8'd0, in_byte};
        rem_nxt      = rem_r - 16'd1;
        if (rem_r == 16'd1) phase_nxt = PH_HEADER;
      end
      PH_SKIP: begin
        rem_nxt = rem_r - 16'd1;
        if (rem_r == 16'd1) phase_nxt = PH_HEADER;
      end
      default: begin
        phase_nxt = PH_HEADER;
        hbp_nxt   = 1'b0;
      end
    endcase

    if (in_end_of_stream) begin
      ent.end_vld    = 1'b1;
      ent.end_status = (phase_nxt == PH_WORDS) || (phase_nxt == PH_LABEL);
      // final byte starts the next file from scratch
      phase_nxt = PH_HEADER;
      hbp_nxt   = 1'b0;
      held_nxt  = '0;
      kind_nxt  = '0;
      addr_nxt  = '0;
      rem_nxt   = '0;
      idx_nxt   = '0;
    end
  end

  assign q_push  = accept & (ent.rec_vld | ent.end_vld);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hbp_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hbp_r   <= hbp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      rem_r  <= rem_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

// File: hdl/osp_queue.sv
// ----------------------------------------------------------------------------
// osp_queue
// short fifo of parsed entries between front and back
// ----------------------------------------------------------------------------
module osp_queue import osp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  osp_entry_t        din,
  input  logic              pop,
  output osp_entry_t        dout,
  output logic              full,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  osp_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + QPTR_W'(1);
      if (do_pop)  rp_r <= rp_r + QPTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

// File: hdl/osp_back.sv
// ----------------------------------------------------------------------------
// osp_back
// result emitter: unpacks queue entries into one or two output words
// ----------------------------------------------------------------------------
module osp_back import osp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  osp_entry_t  q_head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [15:0] out_target_address,
  output logic [15:0] out_payload_value,
  output logic        out_end_status,
  output logic        out_last_of_run
);

  logic        vld_r, vld_nxt;
  logic        sub_r, sub_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] val_r, val_nxt;
  logic        stat_r, stat_nxt;
  logic        last_r, last_nxt;
  logic        load;

  // output register free or being taken this cycle
  assign load = ~vld_r | ~out_stall;

  always_comb begin
    vld_nxt  = vld_r;
    sub_nxt  = sub_r;
    kind_nxt = kind_r;
    addr_nxt = addr_r;
    val_nxt  = val_r;
    stat_nxt = stat_r;
    last_nxt = last_r;
    q_pop    = 1'b0;
    if (load) begin
      if (q_empty) begin
        vld_nxt = 1'b0;
      end else if (q_head.rec_vld && !sub_r) begin
        vld_nxt  = 1'b1;
        kind_nxt = q_head.rec_kind;
        addr_nxt = q_head.rec_addr;
        val_nxt  = q_head.rec_val;
        stat_nxt = 1'b0;
        last_nxt = ~q_head.end_vld;
        // end status follows in a second word
        if (q_head.end_vld) sub_nxt = 1'b1;
        else                q_pop   = 1'b1;
      end else begin
        vld_nxt  = 1'b1;
        kind_nxt = REC_END;
        addr_nxt = '0;
        val_nxt  = '0;
        stat_nxt = q_head.end_status;
        last_nxt = 1'b1;
        sub_nxt  = 1'b0;
        q_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    addr_r <= addr_nxt;
    val_r  <= val_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

  assign out_valid          = vld_r;
  assign out_record_kind    = kind_r;
  assign out_target_address = addr_r;
  assign out_payload_value  = val_r;
  assign out_end_status     = stat_r;
  assign out_last_of_run    = last_r;

endmodule

// File: hdl/object_file_section_parser_top.sv
// ----------------------------------------------------------------------------
// object_file_section_parser_top
// object file byte stream parser emitting memory, label and end words
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_byte, in_end_of_stream
//  out_    | output    | out_valid/out_stall | record kind, address, value,
//          |           |                     | end status, last of run
//
// one byte taken per cycle while the four-entry queue has room
// a byte yielding a record plus end status takes two output words
// with an empty queue a byte's first result passes through the queue, then the output register
// synchronous active-low reset clears the parse phase, queue and output
// output stalls back up through the queue to in_stall
`include "object_file_section_parser_top_defines.svh"

module object_file_section_parser_top import osp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [15:0] out_target_address,
  output logic [15:0] out_payload_value,
  output logic        out_end_status,
  output logic        out_last_of_run
);

  osp_entry_t        push_entry, head_entry;
  logic              q_push, q_pop, q_full, q_empty;
  logic [QCNT_W-1:0] q_count;

  osp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  osp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_entry),
    .pop   (q_pop),
    .dout  (head_entry),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  osp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (head_entry),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_target_address (out_target_address),
    .out_payload_value  (out_payload_value),
    .out_end_status     (out_end_status),
    .out_last_of_run    (out_last_of_run)
  );

  `OSP_ASSERT_NOW(a_end_is_last, out_valid && out_record_kind == REC_END, out_last_of_run)
  `OSP_ASSERT_NOW(a_status_only_on_end, out_valid && out_record_kind != REC_END, !out_end_status)
  `OSP_ASSERT_NOW(a_stall_iff_full, 1'b1, in_stall == (q_count == QCNT_W'(QDEPTH)))
  `OSP_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, q_count != '0)

endmodule
